FILE: rtl/ucep_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the endpoint-zero control handler.
package ucep_pkg;

   // Largest OUT packet taken outside vendor OUT mode.
   localparam logic [6:0] MAX_PACKET = 7'd64;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DEVICE_DESC_LENGTH = 3'd0;
   localparam logic [2:0] REG_CONFIG_DESC_LENGTH = 3'd1;
   localparam logic [2:0] REG_STRING0_LENGTH     = 3'd2;
   localparam logic [2:0] REG_STRING1_LENGTH     = 3'd3;
   localparam logic [2:0] REG_STRING2_LENGTH     = 3'd4;
   localparam logic [2:0] REG_STRING3_LENGTH     = 3'd5;

   // Standard and class request codes.
   localparam logic [7:0] REQ_GET_STATUS             = 8'h00;
   localparam logic [7:0] REQ_SET_ADDRESS            = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR         = 8'h06;
   localparam logic [7:0] REQ_SET_CONFIG             = 8'h09;
   localparam logic [7:0] REQ_SET_INTERFACE          = 8'h0B;
   localparam logic [7:0] REQ_SET_LINE_CODING        = 8'h20;
   localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'h22;

   // Descriptor types and request-type field codes.
   localparam logic [7:0] DESC_DEVICE = 8'd1;
   localparam logic [7:0] DESC_CONFIG = 8'd2;
   localparam logic [7:0] DESC_STRING = 8'd3;
   localparam logic [1:0] RTYPE_VENDOR = 2'd2;
   localparam logic [7:0] STRING_COUNT = 8'd4;
   localparam logic [15:0] STATUS_LENGTH = 16'd2;

   typedef enum logic [1:0] {
      OP_SETUP = 2'd0,
      OP_IN    = 2'd1,
      OP_OUT   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_ZLP     = 3'd1,
      ACT_DEVICE  = 3'd2,
      ACT_CONFIG  = 3'd3,
      ACT_STRING  = 3'd4,
      ACT_STATUS  = 3'd5,
      ACT_VENDOR  = 3'd6
   } action_type;

   // Mode state, one-hot.
   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_ADDR = 3'b010,
      MODE_VOUT = 3'b100
   } mode_type;

   // Mode codes as shown on the result word.
   localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_CODE_ADDR = 2'd1;
   localparam logic [1:0] MODE_CODE_VOUT = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  request_attr;
      logic [7:0]  request_code;
      logic [7:0]  value_low;
      logic [7:0]  value_high;
      logic [15:0] request_length;
      logic        in_more_pending;
      logic [6:0]  out_byte_count;
   } item_type;

   typedef struct packed {
      logic [7:0]  device_desc_length;
      logic [15:0] config_desc_length;
      logic [7:0]  string0_length;
      logic [7:0]  string1_length;
      logic [7:0]  string2_length;
      logic [7:0]  string3_length;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] reply_length;
      logic [1:0]  string_index;
      logic [6:0]  address_value;
      logic        address_enable;
      logic [1:0]  control_mode;
      logic [15:0] out_remaining;
   } result_type;

endpackage

FILE: rtl/usb_control_endpoint_handler.sv
`timescale 1ns / 1ps
// Top level of the USB endpoint-zero control handler.
// Throughput: one word per cycle while rsp_tready is high;
// the decode sits between an input and an output register.
// Reset: synchronous, active high; clears mode, counts, address and valid flags,
// and loads the descriptor length registers with their defaults.
module usb_control_endpoint_handler #(
   parameter logic [6:0] PACKET_LIMIT = ucep_pkg::MAX_PACKET
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, low bit up: request_attr[7:0], request_code[15:8], value_low[23:16],
   // value_high[31:24], request_length[47:32], in_more_pending[48], out_byte_count[55:49]
   input  logic [55:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [1:0]  req_tuser,
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, low bit up: reply_length[15:0], string_index[17:16], address_value[24:18],
   // address_enable[25], control_mode[27:26], out_remaining[43:28], zero fill[47:44]
   output logic [47:0] rsp_tdata,
   // rsp_tuser: action[2:0]
   output logic [2:0]  rsp_tuser,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import ucep_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_vld_ff, in_vld_in;
   result_type rsp_ff, rsp_in;
   logic       out_vld_ff, out_vld_in;
   logic       advance;

   ucep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ucep_core #(
      .PACKET_LIMIT (PACKET_LIMIT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (rsp_in)
   );

   // The held word moves on when the output register is empty or draining.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   // Unpack the request word.
   always_comb begin
      item_in.operation       = req_tuser;
      item_in.request_attr    = req_tdata[7:0];
      item_in.request_code    = req_tdata[15:8];
      item_in.value_low       = req_tdata[23:16];
      item_in.value_high      = req_tdata[31:24];
      item_in.request_length  = req_tdata[47:32];
      item_in.in_more_pending = req_tdata[48];
      item_in.out_byte_count  = req_tdata[55:49];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Pack the response word.
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {4'd0, rsp_ff.out_remaining, rsp_ff.control_mode,
                        rsp_ff.address_enable, rsp_ff.address_value,
                        rsp_ff.string_index, rsp_ff.reply_length};

endmodule

FILE: rtl/ucep_csr.sv
`timescale 1ns / 1ps
// Configuration registers holding the descriptor lengths.
module ucep_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output ucep_pkg::cfg_type    cfg
);
   import ucep_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEVICE_DESC_LENGTH: cfg_in.device_desc_length = csr_data[7:0];
            REG_CONFIG_DESC_LENGTH: cfg_in.config_desc_length = csr_data;
            REG_STRING0_LENGTH:     cfg_in.string0_length     = csr_data[7:0];
            REG_STRING1_LENGTH:     cfg_in.string1_length     = csr_data[7:0];
            REG_STRING2_LENGTH:     cfg_in.string2_length     = csr_data[7:0];
            REG_STRING3_LENGTH:     cfg_in.string3_length     = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_desc_length <= 8'd18;
         cfg_ff.config_desc_length <= 16'd0;
         cfg_ff.string0_length     <= 8'd0;
         cfg_ff.string1_length     <= 8'd0;
         cfg_ff.string2_length     <= 8'd0;
         cfg_ff.string3_length     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ucep_core.sv
`timescale 1ns / 1ps
// Event decode and control state (mode, expected OUT count, pending address).
module ucep_core #(
   parameter logic [6:0] PACKET_LIMIT = ucep_pkg::MAX_PACKET
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ucep_pkg::item_type     item,
   input  ucep_pkg::cfg_type      cfg,
   output ucep_pkg::result_type   result
);
   import ucep_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] expected_ff, expected_in;
   logic [6:0]  address_ff, address_in;

   logic [7:0]  string_len;
   logic [6:0]  take_pkt;
   logic [15:0] take;
   logic [2:0]  action;
   logic [15:0] reply_length;
   logic [1:0]  string_index;
   logic        address_enable;

   // Length of the string descriptor selected by the low index bits.
   always_comb begin
      case (item.value_low[1:0])
         2'd0:    string_len = cfg.string0_length;
         2'd1:    string_len = cfg.string1_length;
         2'd2:    string_len = cfg.string2_length;
         default: string_len = cfg.string3_length;
      endcase
   end

   // Bytes taken from an OUT packet, bounded by the packet limit outside vendor OUT mode, and by the count.
   always_comb begin
      if (mode_ff == MODE_VOUT || item.out_byte_count <= PACKET_LIMIT) begin
         take_pkt = item.out_byte_count;
      end else begin
         take_pkt = PACKET_LIMIT;
      end
      if ({9'd0, take_pkt} > expected_ff) begin
         take = expected_ff;
      end else begin
         take = {9'd0, take_pkt};
      end
   end

   // Main decode of one event.
   always_comb begin
      mode_in        = mode_ff;
      expected_in    = expected_ff;
      address_in     = address_ff;
      action         = ACT_NONE;
      reply_length   = 16'd0;
      string_index   = 2'd0;
      address_enable = 1'b0;
      case (item.operation)
         OP_SETUP: begin
            if (item.request_attr[6:5] == RTYPE_VENDOR) begin
               action = ACT_VENDOR;
               if (!item.request_attr[7]) begin
                  expected_in = item.request_length;
                  mode_in     = MODE_VOUT;
               end
            end else begin
               case (item.request_code)
                  REQ_GET_DESCRIPTOR: begin
                     if (item.value_high == DESC_DEVICE) begin
                        action       = ACT_DEVICE;
                        reply_length = {8'd0, cfg.device_desc_length};
                     end else if (item.value_high == DESC_CONFIG) begin
                        action = ACT_CONFIG;
                        if (cfg.config_desc_length > item.request_length) begin
                           reply_length = item.request_length;
                        end else begin
                           reply_length = cfg.config_desc_length;
                        end
                     end else if (item.value_high == DESC_STRING &&
                                  item.value_low < STRING_COUNT) begin
                        action       = ACT_STRING;
                        string_index = item.value_low[1:0];
                        if ({8'd0, string_len} > item.request_length) begin
                           reply_length = item.request_length;
                        end else begin
                           reply_length = {8'd0, string_len};
                        end
                     end
                  end
                  REQ_SET_ADDRESS: begin
                     address_in = item.value_low[6:0];
                     mode_in    = MODE_ADDR;
                     action     = ACT_ZLP;
                  end
                  REQ_SET_CONFIG, REQ_SET_INTERFACE, REQ_SET_LINE_CODING,
                  REQ_SET_CONTROL_LINE_STATE: begin
                     action = ACT_ZLP;
                  end
                  REQ_GET_STATUS: begin
                     action       = ACT_STATUS;
                     reply_length = STATUS_LENGTH;
                  end
                  default: ;
               endcase
            end
         end
         OP_IN: begin
            // The new address takes effect once the status stage is sent.
            if (!item.in_more_pending && mode_ff == MODE_ADDR) begin
               mode_in        = MODE_IDLE;
               address_enable = 1'b1;
            end
         end
         OP_OUT: begin
            expected_in = expected_ff - take;
            if (expected_in == 16'd0) begin
               mode_in = MODE_IDLE;
               action  = ACT_ZLP;
            end
         end
         default: ;
      endcase
   end

   // Result word, showing the state after this event.
   always_comb begin
      result.action         = action;
      result.reply_length   = reply_length;
      result.string_index   = string_index;
      result.address_value  = address_in;
      result.address_enable = address_enable;
      result.out_remaining  = expected_in;
      case (mode_in)
         MODE_ADDR: result.control_mode = MODE_CODE_ADDR;
         MODE_VOUT: result.control_mode = MODE_CODE_VOUT;
         default:   result.control_mode = MODE_CODE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         expected_ff <= 16'd0;
         address_ff  <= 7'd0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         expected_ff <= expected_in;
         address_ff  <= address_in;
      end
   end

endmodule

FILE: test/tb_usb_control_endpoint_handler.sv
`timescale 1ns / 1ps
// Self-checking testbench of the endpoint-zero control handler: directed table, then random traffic.
module tb_usb_control_endpoint_handler;
   import ucep_pkg::*;

   // Operation code with no meaning; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One row of the directed table: the event, and its reply where it is typed in.
   typedef struct packed {
      item_type   it;
      logic       typed;
      result_type want;
   } stim_row;

   localparam int DIRECTED_COUNT = 26;
   localparam stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Device descriptor right after reset: full length even for a zero wLength.
      '{'{OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 8'h00, DESC_DEVICE, 16'h0000, 1'b1, 7'd64},
        1'b1, '{ACT_DEVICE, 16'd18, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'hFFFF, 1'b0, 7'd0},
        1'b1, '{ACT_CONFIG, 16'd0, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 8'h03, DESC_STRING, 16'hFFFF, 1'b1, 7'd63},
        1'b1, '{ACT_STRING, 16'd0, 2'd3, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      // String index out of range and unknown descriptor type give no reply.
      '{'{OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 8'h04, DESC_STRING, 16'h0040, 1'b0, 7'd1},
        1'b1, '{ACT_NONE, 16'd0, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 8'h00, 8'hFF, 16'h0040, 1'b0, 7'd0},
        1'b1, '{ACT_NONE, 16'd0, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_SETUP, 8'h80, REQ_GET_STATUS, 8'h00, 8'h00, 16'h0002, 1'b0, 7'd0},
        1'b1, '{ACT_STATUS, STATUS_LENGTH, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_SETUP, 8'h00, 8'hFF, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd0},
        1'b1, '{ACT_NONE, 16'd0, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      // Unused operation code with every data bit set.
      '{'{OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 7'd64},
        1'b1, '{ACT_NONE, 16'd0, 2'd0, 7'd0, 1'b0, MODE_CODE_IDLE, 16'd0}},
      // Set-address drops bit 7 of the address.
      '{'{OP_SETUP, 8'h00, REQ_SET_ADDRESS, 8'hFF, 8'hFF, 16'h0000, 1'b0, 7'd0},
        1'b1, '{ACT_ZLP, 16'd0, 2'd0, 7'h7F, 1'b0, MODE_CODE_ADDR, 16'd0}},
      '{'{OP_SETUP, 8'h00, REQ_SET_CONFIG, 8'h01, 8'h00, 16'h0000, 1'b0, 7'd0},
        1'b0, '0},
      '{'{OP_IN, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 7'd0}, 1'b0, '0},
      // Status IN done: the address takes effect on this event only.
      '{'{OP_IN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 7'd64},
        1'b1, '{ACT_NONE, 16'd0, 2'd0, 7'h7F, 1'b1, MODE_CODE_IDLE, 16'd0}},
      '{'{OP_IN, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd0}, 1'b0, '0},
      '{'{OP_SETUP, 8'h01, REQ_SET_INTERFACE, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd0},
        1'b0, '0},
      '{'{OP_SETUP, 8'h21, REQ_SET_LINE_CODING, 8'h00, 8'h00, 16'h0007, 1'b0, 7'd0},
        1'b0, '0},
      '{'{OP_SETUP, 8'h21, REQ_SET_CONTROL_LINE_STATE, 8'h03, 8'h00, 16'h0000, 1'b0, 7'd0},
        1'b0, '0},
      // Vendor OUT, then a standard setup in the middle that leaves the mode alone.
      '{'{OP_SETUP, 8'h40, 8'h5A, 8'h12, 8'h34, 16'd100, 1'b0, 7'd0}, 1'b0, '0},
      '{'{OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd64}, 1'b0, '0},
      '{'{OP_SETUP, 8'h80, REQ_GET_STATUS, 8'h00, 8'h00, 16'h0002, 1'b0, 7'd0}, 1'b0, '0},
      // More bytes than remain: the count saturates at zero.
      '{'{OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd64}, 1'b0, '0},
      '{'{OP_SETUP, 8'hC0, 8'hA5, 8'h00, 8'h00, 16'h0010, 1'b0, 7'd0}, 1'b0, '0},
      '{'{OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd0}, 1'b0, '0},
      '{'{OP_SETUP, 8'h5F, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, 7'd0}, 1'b0, '0},
      // Set-address during vendor OUT switches the mode but keeps the count.
      '{'{OP_SETUP, 8'h00, REQ_SET_ADDRESS, 8'h05, 8'h00, 16'h0000, 1'b0, 7'd0}, 1'b0, '0},
      '{'{OP_OUT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd64}, 1'b0, '0},
      '{'{OP_IN, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 7'd0}, 1'b0, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Shadow copy of the block's registers and state.
   cfg_type     lengths;
   logic [1:0]  ctl_mode;
   logic [15:0] out_left;
   logic [6:0]  addr_latched;

   stim_row     words_offered[$];
   result_type  replies_due[$];
   item_type    planned_events[$];
   int          mismatches = 0;
   bit          tx_eager = 1'b0;
   bit          rx_eager = 1'b0;
   bit          long_hold = 1'b0;

   usb_control_endpoint_handler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #500000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] shorter(logic [15:0] have, logic [15:0] limit);
      return (have > limit) ? limit : have;
   endfunction

   // Works out the reply to one event and advances the shadow state.
   function automatic result_type next_reply(item_type it);
      result_type r;
      logic [15:0] take;
      r = '0;
      case (it.operation)
         OP_SETUP: begin
            if (it.request_attr[6:5] == RTYPE_VENDOR) begin
               r.action = ACT_VENDOR;
               if (!it.request_attr[7]) begin
                  out_left = it.request_length;
                  ctl_mode = MODE_CODE_VOUT;
               end
            end else begin
               case (it.request_code)
                  REQ_GET_DESCRIPTOR: begin
                     if (it.value_high == DESC_DEVICE) begin
                        r.action = ACT_DEVICE;
                        r.reply_length = {8'd0, lengths.device_desc_length};
                     end else if (it.value_high == DESC_CONFIG) begin
                        r.action = ACT_CONFIG;
                        r.reply_length = shorter(lengths.config_desc_length,
                                                 it.request_length);
                     end else if (it.value_high == DESC_STRING &&
                                  it.value_low < STRING_COUNT) begin
                        r.action = ACT_STRING;
                        r.string_index = it.value_low[1:0];
                        case (it.value_low[1:0])
                           2'd0: take = {8'd0, lengths.string0_length};
                           2'd1: take = {8'd0, lengths.string1_length};
                           2'd2: take = {8'd0, lengths.string2_length};
                           default: take = {8'd0, lengths.string3_length};
                        endcase
                        r.reply_length = shorter(take, it.request_length);
                     end
                  end
                  REQ_SET_ADDRESS: begin
                     addr_latched = it.value_low[6:0];
                     ctl_mode = MODE_CODE_ADDR;
                     r.action = ACT_ZLP;
                  end
                  REQ_SET_CONFIG, REQ_SET_INTERFACE, REQ_SET_LINE_CODING,
                  REQ_SET_CONTROL_LINE_STATE: r.action = ACT_ZLP;
                  REQ_GET_STATUS: begin
                     r.action = ACT_STATUS;
                     r.reply_length = STATUS_LENGTH;
                  end
                  default: ;
               endcase
            end
         end
         OP_IN: begin
            if (!it.in_more_pending && ctl_mode == MODE_CODE_ADDR) begin
               ctl_mode = MODE_CODE_IDLE;
               r.address_enable = 1'b1;
            end
         end
         OP_OUT: begin
            take = {9'd0, it.out_byte_count};
            if (ctl_mode != MODE_CODE_VOUT)
               take = shorter(take, {9'd0, MAX_PACKET});
            take = shorter(take, out_left);
            out_left = out_left - take;
            if (out_left == 16'd0) begin
               ctl_mode = MODE_CODE_IDLE;
               r.action = ACT_ZLP;
            end
         end
         default: ;
      endcase
      r.address_value = addr_latched;
      r.control_mode = ctl_mode;
      r.out_remaining = out_left;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Both channels are watched at every edge; the response is taken before the request.
   always @(posedge clock) begin : watch_ports
      result_type seen;
      result_type want;
      result_type guess;
      item_type   arrived;
      stim_row    row;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("response word with no reply due");
            end else begin
               want = replies_due.pop_front();
               seen.action         = rsp_tuser;
               seen.reply_length   = rsp_tdata[15:0];
               seen.string_index   = rsp_tdata[17:16];
               seen.address_value  = rsp_tdata[24:18];
               seen.address_enable = rsp_tdata[25];
               seen.control_mode   = rsp_tdata[27:26];
               seen.out_remaining  = rsp_tdata[43:28];
               check_field("action", 16'(seen.action), 16'(want.action));
               check_field("reply_length", seen.reply_length, want.reply_length);
               check_field("string_index", 16'(seen.string_index), 16'(want.string_index));
               check_field("address_value", 16'(seen.address_value),
                           16'(want.address_value));
               check_field("address_enable", 16'(seen.address_enable),
                           16'(want.address_enable));
               check_field("control_mode", 16'(seen.control_mode), 16'(want.control_mode));
               check_field("out_remaining", seen.out_remaining, want.out_remaining);
               check_field("zero fill", 16'(rsp_tdata[47:44]), 16'd0);
            end
         end
         if (req_tvalid && req_tready) begin
            row = words_offered.pop_front();
            arrived.operation       = req_tuser;
            arrived.request_attr    = req_tdata[7:0];
            arrived.request_code    = req_tdata[15:8];
            arrived.value_low       = req_tdata[23:16];
            arrived.value_high      = req_tdata[31:24];
            arrived.request_length  = req_tdata[47:32];
            arrived.in_more_pending = req_tdata[48];
            arrived.out_byte_count  = req_tdata[55:49];
            guess = next_reply(arrived);
            replies_due.push_back(row.typed ? row.want : guess);
         end
      end
   end

   // Response side: a random stall before each word unless rx_eager is set, and one long hold-off on request.
   initial begin : response_sink
      int stall;
      forever begin
         stall = rx_eager ? 0 : $urandom_range(0, 4);
         if (long_hold) begin
            stall = 60;
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offers one event word after a random gap (none when tx_eager is set) and waits until it is taken.
   task automatic offer_word(stim_row row);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      words_offered.push_back(row);
      req_tvalid <= 1'b1;
      req_tuser  <= row.it.operation;
      req_tdata  <= {row.it.out_byte_count, row.it.in_more_pending, row.it.request_length,
                     row.it.value_high, row.it.value_low, row.it.request_code,
                     row.it.request_attr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEVICE_DESC_LENGTH: lengths.device_desc_length = val[7:0];
         REG_CONFIG_DESC_LENGTH: lengths.config_desc_length = val;
         REG_STRING0_LENGTH:     lengths.string0_length = val[7:0];
         REG_STRING1_LENGTH:     lengths.string1_length = val[7:0];
         REG_STRING2_LENGTH:     lengths.string2_length = val[7:0];
         REG_STRING3_LENGTH:     lengths.string3_length = val[7:0];
         default: ;
      endcase
   endtask

   // Waits until every offered word has been answered, then lets the pipeline drain.
   task automatic wait_for_idle();
      while (replies_due.size() != 0 || words_offered.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // An event of the given kind with every other field random.
   function automatic item_type random_event(logic [1:0] op);
      item_type ev;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      ev = noise[57:0];
      ev.operation = op;
      ev.out_byte_count = 7'($urandom_range(0, 64));
      return ev;
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 70));
         1: return 16'($urandom_range(0, 300));
         2: return 16'($urandom);
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   // Mostly complete control transfers with random content, plus some noise.
   task automatic plan_traffic(int count);
      item_type    ev;
      logic [1:0]  kind;
      logic [15:0] sent;
      int          n;
      int          k;
      while (planned_events.size() < count) begin
         ev = random_event(OP_SETUP);
         kind = 2'($urandom_range(0, 2));
         if (kind == RTYPE_VENDOR)
            kind = 2'd3;
         ev.request_attr[6:5] = kind;
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               ev.request_code = REQ_GET_DESCRIPTOR;
               case ($urandom_range(0, 4))
                  0: ev.value_high = DESC_DEVICE;
                  1: ev.value_high = DESC_CONFIG;
                  2, 3: ev.value_high = DESC_STRING;
                  default: ;
               endcase
               if (ev.value_high == DESC_STRING)
                  ev.value_low = 8'($urandom_range(0, 5));
               ev.request_length = pick_length();
               planned_events.push_back(ev);
               n = $urandom_range(0, 3);
               repeat (n) begin
                  ev = random_event(OP_IN);
                  ev.in_more_pending = 1'b1;
                  planned_events.push_back(ev);
               end
               ev = random_event(OP_IN);
               ev.in_more_pending = 1'b0;
               planned_events.push_back(ev);
            end
            3, 4: begin
               if ($urandom_range(0, 1)) begin
                  ev.request_code = REQ_SET_ADDRESS;
               end else begin
                  case ($urandom_range(0, 4))
                     0: ev.request_code = REQ_SET_CONFIG;
                     1: ev.request_code = REQ_SET_INTERFACE;
                     2: ev.request_code = REQ_SET_LINE_CODING;
                     3: ev.request_code = REQ_SET_CONTROL_LINE_STATE;
                     default: ev.request_code = REQ_GET_STATUS;
                  endcase
               end
               planned_events.push_back(ev);
               ev = random_event(OP_IN);
               ev.in_more_pending = ($urandom_range(0, 3) == 0);
               planned_events.push_back(ev);
               if (ev.in_more_pending) begin
                  ev = random_event(OP_IN);
                  ev.in_more_pending = 1'b0;
                  planned_events.push_back(ev);
               end
            end
            5, 6: begin
               // Vendor OUT: data packets until the count runs out, or cut short.
               ev.request_attr[7] = 1'b0;
               ev.request_attr[6:5] = RTYPE_VENDOR;
               ev.request_length = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                                                                 16'($urandom_range(0, 200));
               planned_events.push_back(ev);
               n = $urandom_range(1, 6);
               k = 0;
               sent = ev.request_length;
               do begin
                  ev = random_event(OP_OUT);
                  planned_events.push_back(ev);
                  sent = sent - shorter({9'd0, ev.out_byte_count}, sent);
                  k++;
               end while (k < n && sent != 16'd0);
            end
            7: begin
               ev.request_attr[7] = 1'b1;
               ev.request_attr[6:5] = RTYPE_VENDOR;
               planned_events.push_back(ev);
               ev = random_event(OP_IN);
               ev.in_more_pending = 1'b0;
               planned_events.push_back(ev);
            end
            8: planned_events.push_back(random_event(OP_OUT));
            default: planned_events.push_back(random_event(2'($urandom_range(0, 3))));
         endcase
      end
   endtask

   initial begin : stimulus
      stim_row     row;
      logic [15:0] val;
      lengths      = '{8'd18, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      ctl_mode     = MODE_CODE_IDLE;
      out_left     = 16'd0;
      addr_latched = 7'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table with the reset register values.
      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_word(DIRECTED_ROWS[i]);
      req_tvalid <= 1'b0;
      wait_for_idle();

      // Random phases; each sets the registers and picks a handshake pattern.
      for (int p = 0; p < 6; p++) begin
         for (int r = REG_DEVICE_DESC_LENGTH; r <= REG_STRING3_LENGTH; r++) begin
            case (p)
               0: val = 16'h0000;
               1: val = 16'hFFFF;
               3, 5: val = 16'($urandom_range(0, 80));
               default: val = 16'($urandom);
            endcase
            write_reg(3'(r), val);
         end
         csr_valid <= 1'b0;
         tx_eager  = (p == 3 || p == 4);
         rx_eager  = (p == 4);
         long_hold = (p == 3);
         plan_traffic(100);
         while (planned_events.size() != 0) begin
            row.it    = planned_events.pop_front();
            row.typed = 1'b0;
            row.want  = '0;
            offer_word(row);
         end
         req_tvalid <= 1'b0;
         wait_for_idle();
      end

      wait_for_idle();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: usb_control_endpoint_handler.f
rtl/ucep_pkg.sv
rtl/ucep_csr.sv
rtl/ucep_core.sv
rtl/usb_control_endpoint_handler.sv
test/tb_usb_control_endpoint_handler.sv
